### design/iceb_pkg.sv
// Shared constants, queue entry type and checksum helper for the ICMP echo request builder.
package iceb_pkg;

    // Field widths of the payload and result beats.
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int OFFSET_W = 11;

    // Largest payload a packet may carry; later bytes are dropped.
    localparam int MAX_PAYLOAD_BYTES = 1472;
    localparam int COUNT_W           = $clog2(MAX_PAYLOAD_BYTES + 1);

    // Header layout.
    localparam logic [BYTE_W-1:0]   ICMP_TYPE_ECHO = 8'd8;
    localparam logic [BYTE_W-1:0]   ICMP_CODE_ECHO = 8'd0;
    localparam logic [OFFSET_W-1:0] HEADER_LEN     = 11'd8;

    // The running sum starts with the type/code word already folded in.
    localparam logic [WORD_W-1:0] SUM_START = {ICMP_TYPE_ECHO, ICMP_CODE_ECHO};

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Back-end step codes: one payload beat, then eight header beats.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_PAYLOAD = 4'd0;
    localparam logic [STEP_W-1:0] STEP_TYPE    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CODE    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_CK_HI   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CK_LO   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ID_HI   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ID_LO   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SEQ_HI  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SEQ_LO  = 4'd8;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ECHO_IDENTIFIER = 1'b0;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic                has_byte;
        logic [BYTE_W-1:0]   data_byte;
        logic [OFFSET_W-1:0] offset;
        logic                has_hdr;
        logic [WORD_W-1:0]   psum;
        logic [WORD_W-1:0]   ident;
        logic [WORD_W-1:0]   seq;
        logic                ovf;
    } iceb_entry_t;

    // Ones'-complement add with end-around carry.
    function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

### design/iceb_front.sv
// Front end: accepts payload items, keeps the running checksum and classifies each item.
module iceb_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [iceb_pkg::BYTE_W-1:0]  payload_byte,
    input  logic                         byte_present,
    input  logic                         end_of_payload,
    input  logic [iceb_pkg::WORD_W-1:0]  ident,
    input  logic                         q_full,
    output logic                         q_push,
    output iceb_pkg::iceb_entry_t        q_entry
);
    import iceb_pkg::*;

    logic [WORD_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0]  held_reg, held_next;
    logic               odd_reg, odd_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0]  seq_reg, seq_next;
    logic               ovf_reg, ovf_next;

    logic               accept;
    logic               drop;
    logic               take;
    logic               last;
    logic               add_en;
    logic [WORD_W-1:0]  add_word;
    logic [WORD_W-1:0]  sum_new;
    logic               ovf_now;

    // Classify the beat: kept byte, dropped byte, close.
    assign accept  = push && !q_full;
    assign drop    = accept && byte_present
                     && (count_reg >= COUNT_W'(MAX_PAYLOAD_BYTES));
    assign take    = accept && byte_present && !drop;
    assign last    = accept && end_of_payload;
    assign ovf_now = ovf_reg || drop;

    // Pick the one word this beat adds to the sum: a completed pair or a padded odd byte.
    always_comb
    begin
        add_en   = 1'b0;
        add_word = '0;
        priority if (take && odd_reg)
        begin
            add_en   = 1'b1;
            add_word = {held_reg, payload_byte};
        end
        else if (take && last)
        begin
            add_en   = 1'b1;
            add_word = {payload_byte, {BYTE_W{1'b0}}};
        end
        else if (last && odd_reg)
        begin
            add_en   = 1'b1;
            add_word = {held_reg, {BYTE_W{1'b0}}};
        end
        else
        begin
            add_en   = 1'b0;
            add_word = '0;
        end
    end

    assign sum_new = add_en ? ones_add(sum_reg, add_word) : sum_reg;

    // Entry handed to the back end.
    assign q_push            = take || last;
    assign q_entry.has_byte  = take;
    assign q_entry.data_byte = payload_byte;
    assign q_entry.offset    = HEADER_LEN + OFFSET_W'(count_reg);
    assign q_entry.has_hdr   = last;
    assign q_entry.psum      = sum_new;
    assign q_entry.ident     = ident;
    assign q_entry.seq       = seq_reg;
    assign q_entry.ovf       = ovf_now;

    // Per-packet state update.
    always_comb
    begin
        sum_next   = sum_reg;
        held_next  = held_reg;
        odd_next   = odd_reg;
        count_next = count_reg;
        seq_next   = seq_reg;
        ovf_next   = ovf_now;
        if (last)
        begin
            sum_next   = SUM_START;
            held_next  = '0;
            odd_next   = 1'b0;
            count_next = '0;
            ovf_next   = 1'b0;
            seq_next   = seq_reg + WORD_W'(1);
        end
        else if (take)
        begin
            count_next = count_reg + COUNT_W'(1);
            if (odd_reg)
            begin
                sum_next = sum_new;
                odd_next = 1'b0;
            end
            else
            begin
                held_next = payload_byte;
                odd_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= SUM_START;
            held_reg  <= '0;
            odd_reg   <= 1'b0;
            count_reg <= '0;
            seq_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            held_reg  <= held_next;
            odd_reg   <= odd_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### design/iceb_queue.sv
// Short FIFO of classified entries between the front and back ends.
module iceb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  iceb_pkg::iceb_entry_t wr_entry,
    input  logic                  rd_en,
    output iceb_pkg::iceb_entry_t rd_entry,
    output logic                  full,
    output logic                  not_empty
);
    import iceb_pkg::*;

    iceb_entry_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic              do_wr;
    logic              do_rd;

    assign full      = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_entry  = slot_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + (QPTR_W + 1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

### design/iceb_back.sv
// Back end: walks each entry out as a payload beat and/or eight header beats.
module iceb_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  iceb_pkg::iceb_entry_t          q_entry,
    output logic                           q_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic [iceb_pkg::OFFSET_W-1:0]  frame_offset,
    output logic [iceb_pkg::BYTE_W-1:0]    frame_byte,
    output logic                           packet_done,
    output logic                           payload_overflow
);
    import iceb_pkg::*;

    logic [STEP_W-1:0]   step_reg;
    logic [WORD_W-1:0]   acc_reg;
    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_done_reg;
    logic                out_ovf_reg;

    logic                advance;
    logic [STEP_W-1:0]   cur_step;
    logic                entry_end;
    logic [OFFSET_W-1:0] beat_offset;
    logic [BYTE_W-1:0]   beat_byte;
    logic [WORD_W-1:0]   cksum;

    // Skip the payload step when the entry only closes the packet.
    assign cur_step  = (step_reg == STEP_PAYLOAD && !q_entry.has_byte) ? STEP_TYPE : step_reg;
    assign advance   = q_valid && (!out_valid_reg || pop);
    assign entry_end = (cur_step == STEP_SEQ_LO)
                       || (cur_step == STEP_PAYLOAD && !q_entry.has_hdr);
    assign q_pop     = advance && entry_end;
    assign cksum     = ~acc_reg;

    // Beat contents for the current step.
    always_comb
    begin
        beat_offset = OFFSET_W'(cur_step) - OFFSET_W'(STEP_TYPE);
        beat_byte   = '0;
        unique case (cur_step)
            STEP_PAYLOAD:
            begin
                beat_offset = q_entry.offset;
                beat_byte   = q_entry.data_byte;
            end
            STEP_TYPE:   beat_byte = ICMP_TYPE_ECHO;
            STEP_CODE:   beat_byte = ICMP_CODE_ECHO;
            STEP_CK_HI:  beat_byte = cksum[WORD_W-1:BYTE_W];
            STEP_CK_LO:  beat_byte = cksum[BYTE_W-1:0];
            STEP_ID_HI:  beat_byte = q_entry.ident[WORD_W-1:BYTE_W];
            STEP_ID_LO:  beat_byte = q_entry.ident[BYTE_W-1:0];
            STEP_SEQ_HI: beat_byte = q_entry.seq[WORD_W-1:BYTE_W];
            STEP_SEQ_LO: beat_byte = q_entry.seq[BYTE_W-1:0];
            default:     beat_byte = '0;
        endcase
    end

    // Step counter and checksum folding: identifier on the type beat, sequence on the code beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_PAYLOAD;
        end
        else if (advance)
        begin
            step_reg <= entry_end ? STEP_PAYLOAD : cur_step + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && cur_step == STEP_TYPE)
        begin
            acc_reg <= ones_add(q_entry.psum, q_entry.ident);
        end
        else if (advance && cur_step == STEP_CODE)
        begin
            acc_reg <= ones_add(acc_reg, q_entry.seq);
        end
    end

    // Output register holding the oldest result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_offset_reg <= beat_offset;
            out_byte_reg   <= beat_byte;
            out_done_reg   <= (cur_step == STEP_SEQ_LO);
            out_ovf_reg    <= q_entry.ovf;
        end
    end

    assign empty            = !out_valid_reg;
    assign frame_offset     = out_offset_reg;
    assign frame_byte       = out_byte_reg;
    assign packet_done      = out_done_reg;
    assign payload_overflow = out_ovf_reg;

endmodule

### design/icmp_echo_request_builder.sv
// ICMP echo request builder: takes one payload byte per cycle, passing each out at message
// offset 8 plus its index while a ones'-complement checksum runs; the item that closes the
// payload adds the eight header beats (type, code, checksum, identifier, sequence) after it,
// so header bytes come after the payload. Result beats leave at one per cycle from the back
// end while pop keeps taking them, so a closing item holds the result side for all its header
// beats; a four-entry queue between the classifying front end and the back end lets payload
// bytes keep arriving at one per cycle meanwhile, and push is refused only when that queue is
// full. Bytes past 1472 in a packet are dropped and flagged on every later beat of the packet.
// The identifier register sits at byte address 0 of the configuration port.
module icmp_echo_request_builder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [iceb_pkg::BYTE_W-1:0]      payload_byte,
    input  logic                             byte_present,
    input  logic                             end_of_payload,
    output logic                             empty,
    input  logic                             pop,
    output logic [iceb_pkg::OFFSET_W-1:0]    frame_offset,
    output logic [iceb_pkg::BYTE_W-1:0]      frame_byte,
    output logic                             packet_done,
    output logic                             payload_overflow,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [iceb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [iceb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [iceb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import iceb_pkg::*;

    logic [WORD_W-1:0] ident_reg;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    iceb_entry_t       q_wr_entry;
    iceb_entry_t       q_rd_entry;
    logic              reg_sel;

    // Configuration register.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_ECHO_IDENTIFIER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            ident_reg <= pwdata[WORD_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(ident_reg) : '0;
    assign full   = q_full;

    iceb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .payload_byte   (payload_byte),
        .byte_present   (byte_present),
        .end_of_payload (end_of_payload),
        .ident          (ident_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_wr_entry)
    );

    iceb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_push),
        .wr_entry  (q_wr_entry),
        .rd_en     (q_pop),
        .rd_entry  (q_rd_entry),
        .full      (q_full),
        .not_empty (q_valid)
    );

    iceb_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_entry          (q_rd_entry),
        .q_pop            (q_pop),
        .pop              (pop),
        .empty            (empty),
        .frame_offset     (frame_offset),
        .frame_byte       (frame_byte),
        .packet_done      (packet_done),
        .payload_overflow (payload_overflow)
    );

endmodule

### design/iceb_checker.sv
// Port-level checks of the echo request builder, bound to the top level.
module iceb_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             empty,
    input  logic                             pop,
    input  logic [iceb_pkg::OFFSET_W-1:0]    frame_offset,
    input  logic [iceb_pkg::BYTE_W-1:0]      frame_byte,
    input  logic                             packet_done
);
    import iceb_pkg::*;

    // A waiting result beat that is not taken stays as it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(frame_offset) && $stable(frame_byte))
        else $error("result beat changed while stalled");

    // The packet ends only on the last header byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && packet_done |-> frame_offset == (HEADER_LEN - OFFSET_W'(1)))
        else $error("packet_done away from the last header byte");

    // The header opens with the echo request type.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && frame_offset == '0 |-> frame_byte == ICMP_TYPE_ECHO)
        else $error("wrong type byte");

    // The code byte is always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && frame_offset == OFFSET_W'(1) |-> frame_byte == ICMP_CODE_ECHO)
        else $error("wrong code byte");

endmodule

bind icmp_echo_request_builder iceb_checker u_iceb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .frame_offset (frame_offset),
    .frame_byte   (frame_byte),
    .packet_done  (packet_done)
);
